[sv/stack_with_deepest_match_removal_assert.svh]
// Assertion macros for the deepest-match stack.
`ifndef STACK_WITH_DEEPEST_MATCH_REMOVAL_ASSERT_SVH
`define STACK_WITH_DEEPEST_MATCH_REMOVAL_ASSERT_SVH

// Check a property while out of reset.
`define SWDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SWDM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/swdm_pkg.sv]
package swdm_pkg;

    localparam int SWDM_DEPTH = 16;
    localparam int VALUE_W    = 32;
    localparam int FIELD_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int OPCODE_W   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // Shift commands broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } t_cell_ctrl;

endpackage

[sv/swdm_cell.sv]
module swdm_cell
    import swdm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [VALUE_W-1:0] i_key,
    input  logic signed [VALUE_W-1:0] i_from_above,
    input  logic signed [VALUE_W-1:0] i_from_below,
    input  logic                      i_match_below,
    input  logic [CW-1:0]             i_pos_below,
    output logic signed [VALUE_W-1:0] o_data,
    output logic                      o_match_chain,
    output logic [CW-1:0]             o_pos_chain
);

    logic signed [VALUE_W-1:0] r_data;
    logic                      w_occupied;
    logic                      w_match;
    logic                      w_deepest;

    assign w_occupied    = i_count > CW'(IDX);
    assign w_match       = w_occupied && (r_data == i_key);
    // Deepest match: this cell matches and nothing below it does.
    assign w_deepest     = w_match && !i_match_below;
    assign o_match_chain = w_match || i_match_below;
    assign o_pos_chain   = w_deepest ? CW'(IDX + 1) : i_pos_below;
    assign o_data        = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_from_above;
        end else if (i_ctrl.pop || (i_ctrl.remove && !i_match_below)) begin
            r_data <= i_from_below;
        end
    end

endmodule

[sv/stack_with_deepest_match_removal.sv]
// Bounded LIFO stack of signed 32-bit words with deepest-match removal.
// Input channel: i_in_valid / o_in_stall carry one beat of i_opcode and
// i_value (push, pop, peek, remove deepest match). Output channel:
// o_out_valid / i_out_stall carry one result beat per input beat with
// o_read_value, o_position, o_status and o_occupancy.
// The result of an accepted beat is registered and shown from the cycle
// after it is accepted. Throughput is one beat per cycle while the receiver
// does not stall; a row of cells, one per entry with the top in cell 0,
// compares every entry with the key and shifts in the same cycle, so the
// match chain across STACK_DEPTH cells sets the cycle time.
// Overflow and underflow leave the stack unchanged and are flagged in
// status. A remove without a match reports position 0.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; entry words are not cleared. While the receiver stalls a
// pending result, it holds and o_in_stall is raised, so no beat is lost.
module stack_with_deepest_match_removal
    import swdm_pkg::*;
#(
    parameter int STACK_DEPTH = SWDM_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [OPCODE_W-1:0]         i_opcode,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VALUE_W-1:0]   o_read_value,
    output logic [FIELD_W-1:0]          o_position,
    output logic [STATUS_W-1:0]         o_status,
    output logic [FIELD_W-1:0]          o_occupancy
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Entry count and the output register.
    logic [CW-1:0]              r_count;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_read_value;
    logic [FIELD_W-1:0]         r_position;
    t_status                    r_status;
    logic [FIELD_W-1:0]         r_occupancy;

    logic [CW-1:0]              n_count;
    logic signed [VALUE_W-1:0]  n_read_value;
    logic [FIELD_W-1:0]         n_position;
    t_status                    n_status;

    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    t_opcode                    w_op;
    t_cell_ctrl                 w_ctrl;

    // Cell row: index 0 is the top; the chains run from the bottom upward.
    logic signed [VALUE_W-1:0]  w_data [STACK_DEPTH];
    logic                       w_match_chain [STACK_DEPTH+1];
    logic [CW-1:0]              w_pos_chain [STACK_DEPTH+1];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = t_opcode'(i_opcode);
    assign w_full     = r_count == CW'(STACK_DEPTH);
    assign w_empty    = r_count == '0;

    assign w_match_chain[STACK_DEPTH] = 1'b0;
    assign w_pos_chain[STACK_DEPTH]   = '0;

    // Broadcast shift commands; push moves everything down one cell, pop moves
    // everything up, remove moves up only the cells at and below the hit.
    assign w_ctrl.push   = w_accept && (w_op == OP_PUSH) && !w_full;
    assign w_ctrl.pop    = w_accept && (w_op == OP_POP) && !w_empty;
    assign w_ctrl.remove = w_accept && (w_op == OP_REMOVE) && w_match_chain[0];

    for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
        logic signed [VALUE_W-1:0] w_above;
        logic signed [VALUE_W-1:0] w_below;

        if (j == 0) begin : g_top
            assign w_above = i_value;
        end else begin : g_mid
            assign w_above = w_data[j-1];
        end

        if (j == STACK_DEPTH - 1) begin : g_bottom
            assign w_below = '0;
        end else begin : g_upper
            assign w_below = w_data[j+1];
        end

        swdm_cell #(
            .IDX (j),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_count       (r_count),
            .i_key         (i_value),
            .i_from_above  (w_above),
            .i_from_below  (w_below),
            .i_match_below (w_match_chain[j+1]),
            .i_pos_below   (w_pos_chain[j+1]),
            .o_data        (w_data[j]),
            .o_match_chain (w_match_chain[j]),
            .o_pos_chain   (w_pos_chain[j])
        );
    end

    // Result of the beat being accepted.
    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_position   = '0;
        n_status     = ST_OK;
        unique case (w_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_OVER;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_UNDER;
                end else begin
                    n_read_value = w_data[0];
                    if (w_op == OP_POP) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_REMOVE: begin
                if (w_match_chain[0]) begin
                    n_position = FIELD_W'(w_pos_chain[0]);
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Hold the count and the pending result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_position   <= n_position;
            r_status     <= n_status;
            r_occupancy  <= FIELD_W'(n_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_position   = r_position;
    assign o_status     = r_status;
    assign o_occupancy  = r_occupancy;

endmodule

[sv/swdm_checker.sv]
`include "stack_with_deepest_match_removal_assert.svh"

module swdm_checker
    import swdm_pkg::*;
#(
    parameter int STACK_DEPTH = SWDM_DEPTH
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [VALUE_W-1:0]   o_read_value,
    input logic [FIELD_W-1:0]          o_position,
    input logic [STATUS_W-1:0]         o_status,
    input logic [FIELD_W-1:0]          o_occupancy
);

    // Hold a stalled result beat.
    `SWDM_ASSERT(a_stall_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value) && $stable(o_occupancy), "stalled result changed")

    // Overflow only when full, and the stack stays full.
    `SWDM_ASSERT(a_over_full, o_out_valid && (o_status == ST_OVER) |-> (o_occupancy == FIELD_W'(STACK_DEPTH)) && (o_read_value == '0), "overflow while not full")

    // Underflow only when empty, with a zero word.
    `SWDM_ASSERT(a_under_empty, o_out_valid && (o_status == ST_UNDER) |-> (o_occupancy == '0) && (o_read_value == '0) && (o_position == '0), "underflow while not empty")

    // No result beat right after reset.
    `SWDM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result beat after reset")

endmodule

bind stack_with_deepest_match_removal swdm_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_swdm_checker (.*);
